// ----- src/scale_frame_weight_parser_assert.svh -----
// Assertion helpers used by the top RTL file of the scale frame parser.
// Each macro expects signals named clk and arst_n in the including scope.
`ifndef SCALE_FRAME_WEIGHT_PARSER_ASSERT_SVH
`define SCALE_FRAME_WEIGHT_PARSER_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SFWP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define SFWP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/sfwp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sfwp_pkg;

	// Reset values of the configuration registers.
	localparam logic [7:0] START_CODE_RST   = 8'h02;
	localparam logic [7:0] END_CODE_RST     = 8'h0D;
	localparam logic [3:0] FRAME_LENGTH_RST = 4'd11;

	// Configuration register indexes.
	localparam logic [1:0] CFG_START_CODE   = 2'd0;
	localparam logic [1:0] CFG_END_CODE     = 2'd1;
	localparam logic [1:0] CFG_FRAME_LENGTH = 2'd2;

	// Result status codes.
	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_LENGTH    = 2'd1;
	localparam logic [1:0] STATUS_SATURATED = 2'd2;

	// Character codes used by the number grammar.
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_CR    = 8'h0D;

	// Largest magnitude the parser holds; larger values saturate here.
	localparam logic [30:0] MAG_MAX = 31'h7FFF_FFFF;

	// Byte counter saturates at its all-ones value.
	localparam logic [3:0] COUNT_MAX = 4'hF;

	typedef enum logic [1:0] {
		PH_LEAD,
		PH_SIGN,
		PH_DIGITS,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic [7:0] start_code;
		logic [7:0] end_code;
		logic [3:0] frame_length;
	} cfg_t;

	typedef struct packed {
		logic               fire;
		logic signed [31:0] weight;
		logic [1:0]         status;
	} result_t;

endpackage

`default_nettype wire

// ----- src/sfwp_cfg_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sfwp_cfg_regs
	import sfwp_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data,
	output cfg_t            cfg
);

	logic [7:0] start_code_q;
	logic [7:0] end_code_q;
	logic [3:0] frame_length_q;

	// Register writes; an index beyond the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_code_q   <= START_CODE_RST;
			end_code_q     <= END_CODE_RST;
			frame_length_q <= FRAME_LENGTH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_START_CODE:   start_code_q   <= cfg_data;
				CFG_END_CODE:     end_code_q     <= cfg_data;
				CFG_FRAME_LENGTH: frame_length_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	assign cfg.start_code   = start_code_q;
	assign cfg.end_code     = end_code_q;
	assign cfg.frame_length = frame_length_q;

endmodule

`default_nettype wire

// ----- src/sfwp_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sfwp_parser
	import sfwp_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] rx_byte,
	input  wire cfg_t       cfg,
	output result_t         res
);

	phase_t      phase_q, phase_d;
	logic        in_frame_q, in_frame_d;
	logic [3:0]  count_q, count_d;
	logic        neg1_q, neg1_d;
	logic        neg2_q, neg2_d;
	logic [30:0] mag_q, mag_d;
	logic        ovf_q, ovf_d;

	logic        is_start;
	logic        is_end;
	logic        is_ws;
	logic        is_sign;
	logic        is_digit;
	logic        payload;
	logic        closing;
	logic        take_digit;
	logic [34:0] mag_x10;
	logic        mag_ovf;
	logic        len_bad;
	logic [31:0] mag_ext;

	// Byte classification.
	assign is_start = (rx_byte == cfg.start_code);
	assign is_end   = (rx_byte == cfg.end_code);
	assign is_ws    = (rx_byte == CHAR_SPACE) || ((rx_byte >= CHAR_TAB) && (rx_byte <= CHAR_CR));
	assign is_sign  = (rx_byte == CHAR_PLUS) || (rx_byte == CHAR_MINUS);
	assign is_digit = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);

	// The start code always wins; inside a frame the end code closes it.
	assign closing = in_frame_q && !is_start && is_end;
	assign payload = in_frame_q && !is_start && !is_end;

	// Multiply-by-ten add of the next digit, with a saturation check.
	assign mag_x10 = ({4'd0, mag_q} << 3) + ({4'd0, mag_q} << 1)
		+ {31'd0, rx_byte[3:0] - CHAR_ZERO[3:0]};
	assign mag_ovf = (mag_x10 > {4'd0, MAG_MAX});

	assign take_digit = payload && is_digit && (phase_q != PH_DONE);

	// Next parse phase.
	always_comb begin
		phase_d = phase_q;
		if (closing) begin
			phase_d = PH_LEAD;
		end else if (payload) begin
			unique case (phase_q)
				PH_LEAD: begin
					if (is_ws) begin
						phase_d = PH_LEAD;
					end else if (is_sign) begin
						phase_d = PH_SIGN;
					end else if (is_digit) begin
						phase_d = PH_DIGITS;
					end else begin
						phase_d = PH_DONE;
					end
				end
				PH_SIGN: begin
					if (is_ws) begin
						phase_d = PH_SIGN;
					end else if (is_sign || is_digit) begin
						phase_d = PH_DIGITS;
					end else begin
						phase_d = PH_DONE;
					end
				end
				PH_DIGITS: begin
					phase_d = is_digit ? PH_DIGITS : PH_DONE;
				end
				default: phase_d = PH_DONE;
			endcase
		end
	end

	// Frame flags, byte count, signs and magnitude.
	always_comb begin
		in_frame_d = in_frame_q;
		count_d    = count_q;
		neg1_d     = neg1_q;
		neg2_d     = neg2_q;
		mag_d      = mag_q;
		ovf_d      = ovf_q;
		if (is_start) begin
			in_frame_d = 1'b1;
		end else if (closing) begin
			in_frame_d = 1'b0;
			count_d    = '0;
			neg1_d     = 1'b0;
			neg2_d     = 1'b0;
			mag_d      = '0;
			ovf_d      = 1'b0;
		end else if (payload) begin
			if (count_q != COUNT_MAX) begin
				count_d = count_q + 4'd1;
			end
			if (is_sign && (phase_q == PH_LEAD)) begin
				neg1_d = (rx_byte == CHAR_MINUS);
			end
			if (is_sign && (phase_q == PH_SIGN)) begin
				neg2_d = (rx_byte == CHAR_MINUS);
			end
			if (take_digit && !ovf_q) begin
				if (mag_ovf) begin
					mag_d = MAG_MAX;
					ovf_d = 1'b1;
				end else begin
					mag_d = mag_x10[30:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_LEAD;
			in_frame_q <= 1'b0;
			count_q    <= '0;
			neg1_q     <= 1'b0;
			neg2_q     <= 1'b0;
			mag_q      <= '0;
			ovf_q      <= 1'b0;
		end else if (step) begin
			phase_q    <= phase_d;
			in_frame_q <= in_frame_d;
			count_q    <= count_d;
			neg1_q     <= neg1_d;
			neg2_q     <= neg2_d;
			mag_q      <= mag_d;
			ovf_q      <= ovf_d;
		end
	end

	// Result for a closing byte, taken by the caller when fire is high.
	assign len_bad = (count_q != cfg.frame_length);
	assign mag_ext = {1'b0, mag_q};

	always_comb begin
		res.fire = closing;
		if (len_bad) begin
			res.weight = '0;
			res.status = STATUS_LENGTH;
		end else begin
			res.weight = (neg1_q ^ neg2_q) ? -$signed(mag_ext) : $signed(mag_ext);
			res.status = ovf_q ? STATUS_SATURATED : STATUS_OK;
		end
	end

endmodule

`default_nettype wire

// ----- src/scale_frame_weight_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "scale_frame_weight_parser_assert.svh"

// Serial scale frame parser. Each input transaction carries one received byte;
// bytes between the start code and the end code are counted and read as a
// signed decimal number (leading whitespace, up to two signs, then digits). The
// end code yields one output transaction with the weight and a status: ok,
// wrong length (weight zero) or saturated at +/-2147483647. One byte is taken
// every cycle while input is not held back: the byte passes an input register,
// and the per-byte update, a compare plus a multiply-by-ten add on the 31-bit
// magnitude, is combinational. A result is loaded into the output register as
// its end code leaves the input register. Input is held back only while a
// closing byte waits for an output register stalled with a pending result.
module scale_frame_weight_parser
	import sfwp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic signed [31:0] weight,
	output logic [1:0]       status
);

	cfg_t    cfg;
	result_t res;

	logic              valid_s1;
	logic [7:0]        rx_byte_s1;
	logic              out_valid_q;
	logic signed [31:0] weight_q;
	logic [1:0]        status_q;

	logic out_free;
	logic advance;
	logic step;
	logic accept_in;

	sfwp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sfwp_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_byte (rx_byte_s1),
		.cfg     (cfg),
		.res     (res)
	);

	// Flow control: a registered byte moves on unless it closes a frame and
	// the output register is still held.
	assign out_free  = !out_valid_q || !out_stall;
	assign advance   = !res.fire || out_free;
	assign step      = valid_s1 && advance;
	assign in_stall  = valid_s1 && !advance;
	assign accept_in = in_valid && !in_stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && res.fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res.fire) begin
			weight_q <= res.weight;
			status_q <= res.status;
		end
	end

	assign out_valid = out_valid_q;
	assign weight    = weight_q;
	assign status    = status_q;

	// Checks on the result register and on the held input byte.
	`SFWP_ASSERT_NOW(a_status_code, out_valid_q, status_q != 2'd3,
		"status code out of range")
	`SFWP_ASSERT_NOW(a_len_zero, out_valid_q && (status_q == STATUS_LENGTH),
		weight_q == 32'sd0, "wrong-length result with non-zero weight")
	`SFWP_ASSERT_NOW(a_sat_value, out_valid_q && (status_q == STATUS_SATURATED),
		(weight_q == 32'sh7FFF_FFFF) || (weight_q == -32'sh7FFF_FFFF),
		"saturated result not at limit")
	`SFWP_ASSERT_NEXT(a_hold_s1, valid_s1 && in_stall,
		valid_s1 && $stable(rx_byte_s1), "held input byte lost or changed")

endmodule

`default_nettype wire

// ----- sim/tb_scale_frame_weight_parser.sv -----
`timescale 1ns / 1ps

module tb_scale_frame_weight_parser;
	import sfwp_pkg::*;

	// One weight reading as it leaves the parser.
	typedef struct packed {
		logic signed [31:0] weight;
		logic [1:0]         status;
	} reading_t;

	// Tracks the parser state byte by byte and holds the readings still owed.
	class weight_scoreboard;
		logic [7:0]  start_code;
		logic [7:0]  end_code;
		logic [3:0]  frame_length;
		bit          in_frame;
		logic [3:0]  byte_count;
		phase_t      parse_state;
		bit          first_negative;
		bit          second_negative;
		logic [30:0] magnitude;
		bit          overflowed;
		reading_t    expected_readings[$];
		int          errors;

		function new();
			start_code   = START_CODE_RST;
			end_code     = END_CODE_RST;
			frame_length = FRAME_LENGTH_RST;
			errors       = 0;
			clear_frame();
		endfunction

		function void clear_frame();
			in_frame        = 0;
			byte_count      = '0;
			parse_state     = PH_LEAD;
			first_negative  = 0;
			second_negative = 0;
			magnitude       = '0;
			overflowed      = 0;
		endfunction

		function void set_register(logic [1:0] index, logic [7:0] value);
			case (index)
				CFG_START_CODE:   start_code = value;
				CFG_END_CODE:     end_code = value;
				CFG_FRAME_LENGTH: frame_length = value[3:0];
				default: ;
			endcase
		endfunction

		// Multiply-by-ten add that sticks at the largest magnitude.
		function void accumulate_digit(logic [7:0] c);
			int unsigned digit;
			int unsigned limit;
			digit = 32'(c - CHAR_ZERO);
			if (overflowed)
				return;
			limit = (MAG_MAX - digit) / 10;
			if (magnitude > limit) begin
				magnitude  = MAG_MAX;
				overflowed = 1;
			end else begin
				magnitude = 31'(magnitude * 10 + digit);
			end
		endfunction

		// Number grammar: whitespace, sign, whitespace, sign, then digits.
		function void parse_payload_byte(logic [7:0] c);
			bit is_sign;
			bit is_space;
			bit is_digit;
			is_sign  = (c == CHAR_PLUS) || (c == CHAR_MINUS);
			is_space = (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
			is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
			case (parse_state)
				PH_LEAD: begin
					if (is_space) begin
					end else if (is_sign) begin
						first_negative = (c == CHAR_MINUS);
						parse_state    = PH_SIGN;
					end else if (is_digit) begin
						accumulate_digit(c);
						parse_state = PH_DIGITS;
					end else begin
						parse_state = PH_DONE;
					end
				end
				PH_SIGN: begin
					if (is_space) begin
					end else if (is_sign) begin
						second_negative = (c == CHAR_MINUS);
						parse_state     = PH_DIGITS;
					end else if (is_digit) begin
						accumulate_digit(c);
						parse_state = PH_DIGITS;
					end else begin
						parse_state = PH_DONE;
					end
				end
				PH_DIGITS: begin
					if (is_digit)
						accumulate_digit(c);
					else
						parse_state = PH_DONE;
				end
				default: ;
			endcase
		endfunction

		// Called for every accepted input transaction.
		function void take_rx_byte(logic [7:0] c);
			reading_t r;
			if (c == start_code) begin
				in_frame = 1;
				return;
			end
			if (!in_frame)
				return;
			if (c == end_code) begin
				if (byte_count != frame_length) begin
					r.weight = '0;
					r.status = STATUS_LENGTH;
				end else begin
					r.weight = {1'b0, magnitude};
					r.status = overflowed ? STATUS_SATURATED : STATUS_OK;
					if (first_negative != second_negative)
						r.weight = -r.weight;
				end
				expected_readings.push_back(r);
				clear_frame();
				return;
			end
			if (byte_count != COUNT_MAX)
				byte_count++;
			parse_payload_byte(c);
		endfunction

		task report(string msg);
			$display("%0t: mismatch: %s", $realtime, msg);
			errors++;
		endtask

		// Called for every accepted output transaction.
		task check_reading(logic signed [31:0] w, logic [1:0] st);
			reading_t want;
			if (expected_readings.size() == 0) begin
				report($sformatf("unexpected reading, weight %0d status %0d", w, st));
				return;
			end
			want = expected_readings.pop_front();
			if (w !== want.weight)
				report($sformatf("weight %0d, expected %0d", w, want.weight));
			if (st !== want.status)
				report($sformatf("status %0d, expected %0d", st, want.status));
		endtask
	endclass

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [1:0]         cfg_index;
	logic [7:0]         cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic [7:0]         rx_byte;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] weight;
	logic [1:0]         status;

	weight_scoreboard sb;
	bit               steady;
	int               hold_cycles;
	int               stall_left;
	int               frame_bytes;
	logic [7:0]       payload_q[$];

	scale_frame_weight_parser i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.rx_byte   (rx_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.weight    (weight),
		.status    (status)
	);

	// Clock with a 10 ns period.
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Idle lengths: mostly short, now and then long.
	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int sender_gap();
		if (steady || $urandom_range(0, 1) == 0)
			return 0;
		return idle_length();
	endfunction

	// Output side stall pattern, including the long hold-off when requested.
	initial begin
		out_stall  = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				out_stall = 1'b1;
				while (hold_cycles > 0) begin
					@(negedge clk);
					hold_cycles--;
				end
				out_stall = 1'b0;
			end else if (steady) begin
				out_stall = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall = 1'b1;
			end else if ($urandom_range(0, 3) == 0) begin
				stall_left = idle_length() - 1;
				out_stall  = 1'b1;
			end else begin
				out_stall = 1'b0;
			end
		end
	end

	// Each accepted output transaction is checked against the oldest reading owed.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_reading(weight, status);
	end

	// Offers one byte after a random gap and waits until it is taken.
	task automatic send_byte(logic [7:0] b);
		int gap;
		gap = sender_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		rx_byte  = b;
		do @(posedge clk); while (in_stall);
		sb.take_rx_byte(b);
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	// Sender pauses until every reading owed has come out.
	task automatic wait_readings();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.expected_readings.size() != 0)
			@(posedge clk);
	endtask

	// Drains the parser and lets a frame that gives no reading finish as well.
	task automatic settle();
		wait_readings();
		repeat (8) @(posedge clk);
	endtask

	task automatic write_register(logic [1:0] index, logic [7:0] value);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = index;
		cfg_data  = value;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.set_register(index, value);
	endtask

	task automatic set_config(logic [7:0] s, logic [7:0] e, logic [3:0] len);
		write_register(CFG_START_CODE, s);
		write_register(CFG_END_CODE, e);
		write_register(CFG_FRAME_LENGTH, {4'h0, len});
	endtask

	function automatic logic [7:0] space_char();
		int r;
		r = $urandom_range(8, 13);
		return (r == 8) ? CHAR_SPACE : 8'(r);
	endfunction

	function automatic logic [7:0] sign_char();
		return $urandom_range(0, 1) ? CHAR_MINUS : CHAR_PLUS;
	endfunction

	function automatic logic [7:0] digit_char();
		return CHAR_ZERO + 8'($urandom_range(0, 9));
	endfunction

	// Builds a payload: mostly numbers in the accepted grammar, some raw noise.
	task automatic build_payload(int len);
		int    style;
		int    r;
		string near_max;
		near_max = "214748364";
		payload_q.delete();
		style = $urandom_range(0, 9);
		if (style < 8) begin
			repeat ($urandom_range(0, 2)) payload_q.push_back(space_char());
			if ($urandom_range(0, 2) > 0)
				payload_q.push_back(sign_char());
			if ($urandom_range(0, 3) == 0)
				payload_q.push_back(space_char());
			if ($urandom_range(0, 3) == 0)
				payload_q.push_back(sign_char());
			if (style == 0) begin
				// Digits around the saturation boundary.
				for (int i = 0; i < near_max.len(); i++)
					payload_q.push_back(near_max[i]);
				payload_q.push_back(digit_char());
			end else begin
				repeat ($urandom_range(0, 12)) payload_q.push_back(digit_char());
			end
			while (payload_q.size() < len) begin
				r = $urandom_range(0, 3);
				if (r == 0)
					payload_q.push_back(digit_char());
				else if (r == 1)
					payload_q.push_back(space_char());
				else if (r == 2)
					payload_q.push_back(sign_char());
				else
					payload_q.push_back(8'($urandom_range(0, 255)));
			end
		end else begin
			repeat (len) payload_q.push_back(8'($urandom_range(0, 255)));
		end
		while (payload_q.size() > len)
			void'(payload_q.pop_back());
	endtask

	// Sends frames under the current settings until the byte budget is spent.
	task automatic run_frames(int budget);
		int len;
		int r;
		frame_bytes = 0;
		while (frame_bytes < budget) begin
			if ($urandom_range(0, 99) < 15)
				repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
			r = $urandom_range(0, 99);
			if (r < 75)
				len = int'(sb.frame_length);
			else if (r < 85)
				len = (sb.frame_length > 0 && r < 80) ? int'(sb.frame_length) - 1
					: int'(sb.frame_length) + 1;
			else
				len = $urandom_range(0, 20);
			build_payload(len);
			send_byte(sb.start_code);
			foreach (payload_q[i])
				send_byte(payload_q[i]);
			frame_bytes += len + 1;
			if ($urandom_range(0, 19) != 0) begin
				send_byte(sb.end_code);
				frame_bytes++;
			end
		end
	endtask

	// Stimulus sequence.
	initial begin
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = CFG_START_CODE;
		cfg_data    = '0;
		in_valid    = 1'b0;
		rx_byte     = '0;
		steady      = 0;
		hold_cycles = 0;
		sb          = new();
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// Directed frames at the reset settings: end code outside a frame,
		// repeated start code, saturation, two signs with a wrong length.
		send_byte(END_CODE_RST);
		send_byte(START_CODE_RST);
		send_byte(START_CODE_RST);
		send_text("-9999999999");
		send_byte(END_CODE_RST);
		send_byte(START_CODE_RST);
		send_text("+-5");
		send_byte(END_CODE_RST);

		// A frame left open across a length change, closed just above the limit.
		send_byte(START_CODE_RST);
		send_byte(CHAR_SPACE);
		send_byte(CHAR_TAB);
		settle();
		write_register(CFG_FRAME_LENGTH, 8'd13);
		send_text("-2147483648");
		send_byte(END_CODE_RST);

		// Register extremes.
		settle();
		set_config(8'h00, 8'hFF, 4'd14);
		run_frames(150);
		settle();
		set_config(8'hFF, 8'h00, 4'd1);
		run_frames(150);

		// Saturating byte count, with a whitespace end code.
		settle();
		set_config(8'h3A, 8'h0A, 4'd15);
		run_frames(150);

		// Empty payload is the only right length.
		settle();
		set_config(START_CODE_RST, END_CODE_RST, 4'd0);
		run_frames(120);

		// Start and end codes equal: frames never close.
		settle();
		set_config(8'h55, 8'h55, 4'd5);
		run_frames(60);

		// Back-to-back transactions with no idling at all.
		settle();
		steady = 1;
		set_config(START_CODE_RST, END_CODE_RST, FRAME_LENGTH_RST);
		run_frames(150);
		steady = 0;

		// Long output hold-off with short frames, so the input backs up.
		settle();
		set_config(START_CODE_RST, END_CODE_RST, 4'd2);
		hold_cycles = 300;
		run_frames(120);

		// Sender waits for every reading halfway through.
		settle();
		set_config(8'h7E, 8'h0D, 4'd6);
		run_frames(75);
		wait_readings();
		run_frames(75);

		// Random settings.
		repeat (3) begin
			settle();
			set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				4'($urandom_range(1, 14)));
			run_frames(100);
		end

		settle();
		if (sb.errors == 0)
			$display("[scale_frame_weight_parser] OK");
		else
			$display("[scale_frame_weight_parser] ERROR");
		$finish;
	end

	// Run limit.
	initial begin
		#10_000_000;
		$display("[scale_frame_weight_parser] ERROR");
		$finish;
	end

endmodule
